/* src/i2cms_pkg.sv */
// i2cms_pkg: shared types, codes and the control store of the i2c master byte sequencer
// no dependencies; used by i2cms_seq, i2c_master_byte_sequencer and i2cms_check
package i2cms_pkg;

	typedef enum logic [1:0] {
		SYM_START  = 2'd0,
		SYM_DRIVE  = 2'd1,
		SYM_SAMPLE = 2'd2,
		SYM_STOP   = 2'd3
	} sym_t;

	typedef enum logic [1:0] {
		ST_BUSY = 2'd0,
		ST_OK   = 2'd1,
		ST_FAIL = 2'd2
	} stat_t;

	// where the data line level of a symbol comes from
	typedef enum logic [2:0] {
		SDA_ZERO  = 3'd0,
		SDA_ONE   = 3'd1,
		SDA_CTL   = 3'd2,
		SDA_WR    = 3'd3,
		SDA_RX    = 3'd4,
		SDA_ANACK = 3'd5,
		SDA_DNACK = 3'd6,
		SDA_LAST  = 3'd7
	} sda_sel_t;

	// what follows a step once its symbols are out
	typedef enum logic [2:0] {
		BR_SEQ  = 3'd0,
		BR_ADDR = 3'd1,
		BR_DATA = 3'd2,
		BR_LAST = 3'd3,
		BR_DONE = 3'd4
	} br_t;

	typedef enum logic [3:0] {
		UC_START = 4'd0,
		UC_CTL   = 4'd1,
		UC_AACK  = 4'd2,
		UC_WR    = 4'd3,
		UC_DACK  = 4'd4,
		UC_RD    = 4'd5,
		UC_MACK  = 4'd6,
		UC_STOP  = 4'd7,
		UC_FAIL  = 4'd8
	} uaddr_t;

	typedef struct packed {
		sym_t     sym;
		sda_sel_t sda;
		logic     rep;
		br_t      br;
		stat_t    stat;
		logic     rx_ok;
		logic     clr_trans;
	} ucode_t;

	// branch conditions seen by the sequencer
	typedef struct packed {
		logic addr_nack;
		logic data_nack;
		logic last;
		logic dir;
	} seq_cond_t;

	// control store, one word per step
	function automatic ucode_t ucode(input uaddr_t a);
		ucode_t w;
		w = '{SYM_STOP, SDA_ONE, 1'b0, BR_DONE, ST_BUSY, 1'b0, 1'b0};
		unique case (a)
			UC_START: w = '{SYM_START,  SDA_ZERO,  1'b0, BR_SEQ,  ST_BUSY, 1'b0, 1'b0};
			UC_CTL:   w = '{SYM_DRIVE,  SDA_CTL,   1'b1, BR_SEQ,  ST_BUSY, 1'b0, 1'b0};
			UC_AACK:  w = '{SYM_SAMPLE, SDA_ANACK, 1'b0, BR_ADDR, ST_BUSY, 1'b0, 1'b0};
			UC_WR:    w = '{SYM_DRIVE,  SDA_WR,    1'b1, BR_SEQ,  ST_BUSY, 1'b0, 1'b0};
			UC_DACK:  w = '{SYM_SAMPLE, SDA_DNACK, 1'b0, BR_DATA, ST_BUSY, 1'b0, 1'b0};
			UC_RD:    w = '{SYM_SAMPLE, SDA_RX,    1'b1, BR_SEQ,  ST_BUSY, 1'b0, 1'b0};
			UC_MACK:  w = '{SYM_DRIVE,  SDA_LAST,  1'b0, BR_LAST, ST_BUSY, 1'b1, 1'b0};
			UC_STOP:  w = '{SYM_STOP,   SDA_ONE,   1'b0, BR_DONE, ST_OK,   1'b1, 1'b1};
			UC_FAIL:  w = '{SYM_STOP,   SDA_ONE,   1'b0, BR_DONE, ST_FAIL, 1'b0, 1'b1};
			default:  w = '{SYM_STOP,   SDA_ONE,   1'b0, BR_DONE, ST_BUSY, 1'b0, 1'b0};
		endcase
		return w;
	endfunction

endpackage

/* src/i2cms_seq.sv */
// i2cms_seq: step counter, bit repeat counter and jump logic of the control program
// depends on i2cms_pkg (control store, word and condition types)
module i2cms_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  i2cms_pkg::uaddr_t   start_pc,
	input  logic                step,
	input  i2cms_pkg::seq_cond_t cond,
	output i2cms_pkg::ucode_t   uw,
	output logic [2:0]          bit_idx,
	output logic                done,
	output logic                busy
);

	i2cms_pkg::uaddr_t pc_q;
	i2cms_pkg::uaddr_t npc;
	logic [2:0]        bit_q;
	logic              busy_q;
	logic              rep_more;

	assign uw       = i2cms_pkg::ucode(pc_q);
	assign bit_idx  = bit_q;
	assign busy     = busy_q;
	assign rep_more = uw.rep && (bit_q != 3'd7);

	always_comb begin
		npc  = i2cms_pkg::uaddr_t'(pc_q + 4'd1);
		done = 1'b0;
		if (rep_more) begin
			npc = pc_q;
		end else begin
			unique case (uw.br)
				i2cms_pkg::BR_SEQ: begin
					npc = i2cms_pkg::uaddr_t'(pc_q + 4'd1);
				end
				i2cms_pkg::BR_ADDR: begin
					if (cond.addr_nack) begin
						npc = i2cms_pkg::UC_FAIL;
					end else begin
						npc = cond.dir ? i2cms_pkg::UC_RD : i2cms_pkg::UC_WR;
					end
				end
				i2cms_pkg::BR_DATA: begin
					if (cond.data_nack) begin
						npc = i2cms_pkg::UC_FAIL;
					end else if (cond.last) begin
						npc = i2cms_pkg::UC_STOP;
					end else begin
						done = 1'b1;
					end
				end
				i2cms_pkg::BR_LAST: begin
					if (cond.last) begin
						npc = i2cms_pkg::UC_STOP;
					end else begin
						done = 1'b1;
					end
				end
				default: begin
					done = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= i2cms_pkg::UC_START;
			bit_q  <= 3'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			pc_q   <= start_pc;
			bit_q  <= 3'd0;
		end else if (step) begin
			if (done) begin
				busy_q <= 1'b0;
			end
			pc_q  <= npc;
			bit_q <= rep_more ? bit_q + 3'd1 : 3'd0;
		end
	end

endmodule

/* src/i2c_master_byte_sequencer.sv */
// i2c_master_byte_sequencer: top level, item capture, symbol datapath and output register
// depends on i2cms_pkg and i2cms_seq
//
//  channel | signals                                          | dir
//  in      | in_valid in_ready is_read dev_addr wr_data first | in
//          | last addr_nack data_nack rx_byte_in              |
//  out     | out_valid out_ready symbol sda_level status      | out
//          | rx_byte run_last                                 |
//
// one bus symbol per clock from the control program; a slot gives 9 to 20 symbols,
// and none for a beat taken outside a transaction
// the next input beat is taken the cycle after the final symbol enters the output register
// a stalled output register holds the step counter, so stalls add cycles one for one
// reset returns the bus to idle with no transaction open
module i2c_master_byte_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       is_read,
	input  logic [6:0] dev_addr,
	input  logic [7:0] wr_data,
	input  logic       first,
	input  logic       last,
	input  logic       addr_nack,
	input  logic       data_nack,
	input  logic [7:0] rx_byte_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] symbol,
	output logic       sda_level,
	output logic [1:0] status,
	output logic [7:0] rx_byte,
	output logic       run_last
);

	i2cms_pkg::ucode_t    uw;
	i2cms_pkg::seq_cond_t cond;
	i2cms_pkg::uaddr_t    start_pc;
	logic [2:0]           bit_idx;
	logic [2:0]           bit_pos;
	logic                 done;
	logic                 busy;
	logic                 accept;
	logic                 start;
	logic                 step;
	logic                 sda;

	logic [7:0] ctl_q;
	logic [7:0] wr_q;
	logic [7:0] rx_q;
	logic       last_q;
	logic       anack_q;
	logic       dnack_q;
	logic       dir_q;
	logic       in_trans_q;

	logic       out_valid_q;
	logic [1:0] sym_q;
	logic       sda_q;
	logic [1:0] stat_q;
	logic [7:0] rx_byte_q;
	logic       run_last_q;

	assign in_ready = !busy;
	assign accept   = in_valid && in_ready;
	assign start    = accept && (first || in_trans_q);
	assign step     = busy && (!out_valid_q || out_ready);
	assign bit_pos  = ~bit_idx;

	always_comb begin
		if (first) begin
			start_pc = i2cms_pkg::UC_START;
		end else begin
			start_pc = dir_q ? i2cms_pkg::UC_RD : i2cms_pkg::UC_WR;
		end
	end

	assign cond = '{addr_nack: anack_q, data_nack: dnack_q, last: last_q, dir: dir_q};

	i2cms_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.start_pc (start_pc),
		.step     (step),
		.cond     (cond),
		.uw       (uw),
		.bit_idx  (bit_idx),
		.done     (done),
		.busy     (busy)
	);

	always_comb begin
		unique case (uw.sda)
			i2cms_pkg::SDA_ZERO:  sda = 1'b0;
			i2cms_pkg::SDA_ONE:   sda = 1'b1;
			i2cms_pkg::SDA_CTL:   sda = ctl_q[bit_pos];
			i2cms_pkg::SDA_WR:    sda = wr_q[bit_pos];
			i2cms_pkg::SDA_RX:    sda = rx_q[bit_pos];
			i2cms_pkg::SDA_ANACK: sda = anack_q;
			i2cms_pkg::SDA_DNACK: sda = dnack_q;
			i2cms_pkg::SDA_LAST:  sda = last_q;
			default:              sda = 1'b1;
		endcase
	end

	// beat payload, held for the whole slot
	always_ff @(posedge clk) begin
		if (accept) begin
			if (first) begin
				ctl_q <= {dev_addr, is_read};
			end
			wr_q    <= wr_data;
			rx_q    <= rx_byte_in;
			last_q  <= last;
			anack_q <= addr_nack;
			dnack_q <= data_nack;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q      <= 1'b0;
			in_trans_q <= 1'b0;
		end else if (accept && first) begin
			dir_q      <= is_read;
			in_trans_q <= 1'b1;
		end else if (step && uw.clr_trans) begin
			in_trans_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			sym_q      <= uw.sym;
			sda_q      <= sda;
			stat_q     <= uw.stat;
			rx_byte_q  <= (done && uw.rx_ok && dir_q) ? rx_q : 8'd0;
			run_last_q <= done;
		end
	end

	assign out_valid = out_valid_q;
	assign symbol    = sym_q;
	assign sda_level = sda_q;
	assign status    = stat_q;
	assign rx_byte   = rx_byte_q;
	assign run_last  = run_last_q;

endmodule

/* src/i2cms_check.sv */
// i2cms_check: port-level checks on the symbol stream of i2c_master_byte_sequencer
// depends on i2cms_pkg codes; bound to the top level at the end of this file
module i2cms_check (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] symbol,
	input logic       sda_level,
	input logic [1:0] status,
	input logic [7:0] rx_byte,
	input logic       run_last
);

	// stalled output beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(symbol) && $stable(sda_level)
			&& $stable(status) && $stable(rx_byte) && $stable(run_last))
		else $error("output beat changed while stalled");

	// a finishing status only rides on a stop that closes the slot
	a_status_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != i2cms_pkg::ST_BUSY |->
			symbol == i2cms_pkg::SYM_STOP && run_last)
		else $error("status outside a final stop");

	// start pulls sda low, stop releases it
	a_cond_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (symbol == i2cms_pkg::SYM_START || symbol == i2cms_pkg::SYM_STOP) |->
			sda_level == (symbol == i2cms_pkg::SYM_STOP))
		else $error("wrong sda level on start or stop");

	// read data shows only on the last symbol of a slot
	a_rx_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rx_byte != 8'd0 |-> run_last)
		else $error("read byte before end of slot");

	// a start never ends a slot
	a_start_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && symbol == i2cms_pkg::SYM_START |-> !run_last)
		else $error("slot ended on start");

endmodule

bind i2c_master_byte_sequencer i2cms_check u_i2cms_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.symbol    (symbol),
	.sda_level (sda_level),
	.status    (status),
	.rx_byte   (rx_byte),
	.run_last  (run_last)
);
